>>> sv/coapmp_pkg.sv
// coapmp_pkg: shared types and constants of the coap message parser
// parse phases, byte roles, error codes, parser state and per-beat result
// no dependencies
package coapmp_pkg;

  localparam int unsigned DataW    = 8;
  localparam int unsigned LenW     = 17;
  localparam int unsigned OptNumW  = 16;
  localparam int unsigned OutDataW = 80;
  localparam int unsigned OutUserW = 3;

  localparam logic [1:0]      CoapVersion   = 2'b01;
  localparam logic [3:0]      NibbleExt1    = 4'd13;
  localparam logic [3:0]      NibbleReserved = 4'd15;
  localparam logic [LenW-1:0] Ext1Offset    = 17'd13;
  localparam logic [LenW-1:0] Ext2Offset    = 17'd269;
  localparam logic [OptNumW-1:0] UriPathOpt = 16'd11;

  typedef enum logic [3:0] {
    PH_HDR     = 4'd0,
    PH_TOKEN   = 4'd1,
    PH_OHEAD   = 4'd2,
    PH_DEXT_A  = 4'd3,
    PH_DEXT_B  = 4'd4,
    PH_LEXT_A  = 4'd5,
    PH_LEXT_B  = 4'd6,
    PH_VALUE   = 4'd7,
    PH_PAYLOAD = 4'd8,
    PH_IGNORE  = 4'd9
  } phase_e;

  typedef enum logic [2:0] {
    ROLE_HEADER  = 3'd0,
    ROLE_TOKEN   = 3'd1,
    ROLE_OHEAD   = 3'd2,
    ROLE_OEXT    = 3'd3,
    ROLE_OVALUE  = 3'd4,
    ROLE_MARKER  = 3'd5,
    ROLE_PAYLOAD = 3'd6,
    ROLE_IGNORED = 3'd7
  } role_e;

  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_SHORT    = 3'd1,
    ERR_VERSION  = 3'd2,
    ERR_TOKENCUT = 3'd3,
    ERR_OPTCUT   = 3'd4,
    ERR_RESERVED = 3'd5
  } err_e;

  typedef struct packed {
    phase_e              phase;
    logic [1:0]          header_count;
    logic [1:0]          type_reg;
    logic [3:0]          tkl_reg;
    logic [3:0]          token_left;
    logic [7:0]          code_reg;
    logic [15:0]         id_reg;
    logic [3:0]          delta_nibble;
    logic [3:0]          length_nibble;
    logic [LenW-1:0]     ext_accum;
    logic [OptNumW-1:0]  opt_number;
    logic [LenW-1:0]     value_left;
    err_e                error;
  } state_t;

  typedef struct packed {
    role_e               byte_role;
    logic [7:0]          byte_out;
    logic [1:0]          msg_type;
    logic [3:0]          token_len;
    logic [7:0]          msg_code;
    logic [15:0]         msg_id;
    logic [OptNumW-1:0]  opt_number;
    logic [LenW-1:0]     opt_length;
    logic                opt_end;
    logic                uri_path;
    logic                frame_done;
    err_e                error_code;
  } result_t;

endpackage

>>> sv/coapmp_decode.sv
// coapmp_decode: next parser state and result for one datagram byte
// purely combinational, depends on coapmp_pkg
module coapmp_decode (
  input  coapmp_pkg::state_t  state_i,
  input  logic [7:0]          data_i,
  input  logic                last_i,
  output coapmp_pkg::state_t  state_o,
  output coapmp_pkg::result_t result_o
);

  coapmp_pkg::state_t      nx;
  coapmp_pkg::role_e       role;
  logic                    oend;
  logic                    dknown;
  logic                    lknown;
  logic                    do_delta;
  logic                    do_after;
  logic                    do_len;
  logic [16:0]             delta_add;
  logic [16:0]             len_val;
  logic [16:0]             ext_pair;
  logic [16:0]             byte_ext;
  logic [3:0]              dn;
  logic [3:0]              ln;
  logic                    optrole;

  assign dn       = data_i[7:4];
  assign ln       = data_i[3:0];
  assign ext_pair = {1'b0, state_i.ext_accum[7:0], data_i};
  assign byte_ext = {9'b0, data_i};

  always_comb begin
    nx        = state_i;
    role      = coapmp_pkg::ROLE_IGNORED;
    oend      = 1'b0;
    dknown    = 1'b0;
    lknown    = 1'b0;
    do_delta  = 1'b0;
    do_after  = 1'b0;
    do_len    = 1'b0;
    delta_add = '0;
    len_val   = '0;

    unique case (state_i.phase)
      coapmp_pkg::PH_HDR: begin
        role = coapmp_pkg::ROLE_HEADER;
        unique case (state_i.header_count)
          2'd0: begin
            if (data_i[7:6] != coapmp_pkg::CoapVersion) nx.error = coapmp_pkg::ERR_VERSION;
            nx.type_reg = data_i[5:4];
            nx.tkl_reg  = data_i[3:0];
          end
          2'd1: nx.code_reg = data_i;
          2'd2: nx.id_reg   = {data_i, 8'h00};
          default: begin
            nx.id_reg     = {state_i.id_reg[15:8], data_i};
            nx.token_left = state_i.tkl_reg;
            if (nx.error != coapmp_pkg::ERR_OK) begin
              nx.phase = coapmp_pkg::PH_IGNORE;
            end else if (state_i.tkl_reg != 4'd0) begin
              nx.phase = coapmp_pkg::PH_TOKEN;
            end else begin
              nx.phase = coapmp_pkg::PH_OHEAD;
            end
          end
        endcase
        if (last_i && state_i.header_count != 2'd3) nx.error = coapmp_pkg::ERR_SHORT;
        nx.header_count = state_i.header_count + 2'd1;
      end
      coapmp_pkg::PH_TOKEN: begin
        role          = coapmp_pkg::ROLE_TOKEN;
        nx.token_left = state_i.token_left - 4'd1;
        if (nx.token_left == 4'd0) nx.phase = coapmp_pkg::PH_OHEAD;
      end
      coapmp_pkg::PH_OHEAD: begin
        role = coapmp_pkg::ROLE_OHEAD;
        if (dn == coapmp_pkg::NibbleReserved && ln == coapmp_pkg::NibbleReserved) begin
          role     = coapmp_pkg::ROLE_MARKER;
          nx.phase = coapmp_pkg::PH_PAYLOAD;
        end else if (dn == coapmp_pkg::NibbleReserved || ln == coapmp_pkg::NibbleReserved) begin
          nx.error = coapmp_pkg::ERR_RESERVED;
          nx.phase = coapmp_pkg::PH_IGNORE;
        end else begin
          nx.delta_nibble  = dn;
          nx.length_nibble = ln;
          if (dn >= coapmp_pkg::NibbleExt1) begin
            nx.phase = coapmp_pkg::PH_DEXT_A;
          end else begin
            delta_add = {13'b0, dn};
            do_delta  = 1'b1;
            do_after  = 1'b1;
          end
        end
      end
      coapmp_pkg::PH_DEXT_A: begin
        role = coapmp_pkg::ROLE_OEXT;
        if (state_i.delta_nibble == coapmp_pkg::NibbleExt1) begin
          delta_add = coapmp_pkg::Ext1Offset + byte_ext;
          do_delta  = 1'b1;
          do_after  = 1'b1;
        end else begin
          nx.ext_accum = byte_ext;
          nx.phase     = coapmp_pkg::PH_DEXT_B;
        end
      end
      coapmp_pkg::PH_DEXT_B: begin
        role      = coapmp_pkg::ROLE_OEXT;
        delta_add = coapmp_pkg::Ext2Offset + ext_pair;
        do_delta  = 1'b1;
        do_after  = 1'b1;
      end
      coapmp_pkg::PH_LEXT_A: begin
        role   = coapmp_pkg::ROLE_OEXT;
        dknown = 1'b1;
        if (state_i.length_nibble == coapmp_pkg::NibbleExt1) begin
          len_val = coapmp_pkg::Ext1Offset + byte_ext;
          do_len  = 1'b1;
        end else begin
          nx.ext_accum = byte_ext;
          nx.phase     = coapmp_pkg::PH_LEXT_B;
        end
      end
      coapmp_pkg::PH_LEXT_B: begin
        role    = coapmp_pkg::ROLE_OEXT;
        dknown  = 1'b1;
        len_val = coapmp_pkg::Ext2Offset + ext_pair;
        do_len  = 1'b1;
      end
      coapmp_pkg::PH_VALUE: begin
        role          = coapmp_pkg::ROLE_OVALUE;
        dknown        = 1'b1;
        lknown        = 1'b1;
        nx.value_left = state_i.value_left - 17'd1;
        if (nx.value_left == '0) begin
          oend     = 1'b1;
          nx.phase = coapmp_pkg::PH_OHEAD;
        end
      end
      coapmp_pkg::PH_PAYLOAD: role = coapmp_pkg::ROLE_PAYLOAD;
      default:                role = coapmp_pkg::ROLE_IGNORED;
    endcase

    // running option number, then length form of the current option
    if (do_delta) begin
      nx.opt_number = state_i.opt_number + delta_add[15:0];
      dknown        = 1'b1;
    end
    if (do_after) begin
      if (nx.length_nibble >= coapmp_pkg::NibbleExt1) begin
        nx.phase = coapmp_pkg::PH_LEXT_A;
      end else begin
        len_val = {13'b0, nx.length_nibble};
        do_len  = 1'b1;
      end
    end
    if (do_len) begin
      nx.ext_accum  = len_val;
      nx.value_left = len_val;
      lknown        = 1'b1;
      if (len_val != '0) begin
        nx.phase = coapmp_pkg::PH_VALUE;
      end else begin
        nx.phase = coapmp_pkg::PH_OHEAD;
        oend     = 1'b1;
      end
    end

    // truncation at end of datagram
    if (last_i && nx.error == coapmp_pkg::ERR_OK) begin
      if (nx.phase == coapmp_pkg::PH_TOKEN) begin
        nx.error = coapmp_pkg::ERR_TOKENCUT;
      end else if (nx.phase >= coapmp_pkg::PH_DEXT_A && nx.phase <= coapmp_pkg::PH_VALUE) begin
        nx.error = coapmp_pkg::ERR_OPTCUT;
      end
    end
  end

  assign optrole = (role == coapmp_pkg::ROLE_OHEAD) || (role == coapmp_pkg::ROLE_OEXT) ||
                   (role == coapmp_pkg::ROLE_OVALUE);

  always_comb begin
    result_o.byte_role  = role;
    result_o.byte_out   = data_i;
    result_o.msg_type   = nx.type_reg;
    result_o.token_len  = nx.tkl_reg;
    result_o.msg_code   = nx.code_reg;
    result_o.msg_id     = nx.id_reg;
    result_o.opt_number = optrole ? nx.opt_number : '0;
    result_o.opt_length = (optrole && lknown) ? nx.ext_accum : '0;
    result_o.opt_end    = optrole && oend;
    result_o.uri_path   = optrole && dknown && (nx.opt_number == coapmp_pkg::UriPathOpt);
    result_o.frame_done = last_i;
    result_o.error_code = nx.error;
  end

  // a new datagram starts after its last byte
  assign state_o = last_i ? coapmp_pkg::state_t'('0) : nx;

endmodule

>>> sv/coap_message_parser_top.sv
// coap_message_parser_top: byte-stream coap message parser
// input register, parser state register and result register around coapmp_decode
// depends on coapmp_pkg and coapmp_decode
//
// usage:
//   s_axis carries one datagram byte per beat, tlast on the final byte.
//   m_axis returns one beat per input byte: the byte echoed, its role in
//   tuser, and the header fields, option number and length, option end,
//   uri-path flag and error code in tdata; tlast marks the datagram end.
//   each accepted input beat is registered in the input register, its result in the result register.
//   throughput is one byte per cycle while m_axis_tready stays high, set by
//   the state update of the parser state register.
//   the parser state returns to its header phase after every last byte,
//   so datagrams follow each other with no gap.
//   reset clears the input and result valid flags and the parser state;
//   beats in flight are dropped.
//   when m_axis_tready is low the result register holds its beat, the
//   input register fills, and s_axis_tready then drops until a beat leaves.
module coap_message_parser_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // data_byte
  input  logic                               s_axis_tlast,  // frame_last
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // byte_out, msg_type, token_len, msg_code, msg_id, opt_number, opt_length,
  // opt_end, uri_path, error_code, zero fill
  output logic [coapmp_pkg::OutDataW-1:0]    m_axis_tdata,
  output logic [coapmp_pkg::OutUserW-1:0]    m_axis_tuser,  // byte_role
  output logic                               m_axis_tlast   // frame_done
);

  logic                 in_v_q;
  logic [7:0]           in_data_q;
  logic                 in_last_q;
  logic                 out_v_q;
  logic                 adv;
  coapmp_pkg::state_t   state_q;
  coapmp_pkg::state_t   state_d;
  coapmp_pkg::result_t  res_d;
  coapmp_pkg::result_t  res_q;

  assign adv           = !out_v_q || m_axis_tready;
  assign s_axis_tready = !in_v_q || adv;

  coapmp_decode u_decode (
    .state_i  (state_q),
    .data_i   (in_data_q),
    .last_i   (in_last_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      state_q <= '0;
    end else begin
      if (s_axis_tready) in_v_q <= s_axis_tvalid;
      if (adv) out_v_q <= in_v_q;
      if (in_v_q && adv) state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (in_v_q && adv) res_q <= res_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = res_q.byte_role;
  assign m_axis_tlast  = res_q.frame_done;
  assign m_axis_tdata  = {4'b0, res_q.error_code, res_q.uri_path, res_q.opt_end,
                          res_q.opt_length, res_q.opt_number, res_q.msg_id,
                          res_q.msg_code, res_q.token_len, res_q.msg_type,
                          res_q.byte_out};

endmodule
